FILE: rtl/core/ilc_pkg.sv
// Package for the indexed list with compaction.
// Holds sizes, request and status codes, and shared structs; no dependencies.
`timescale 1ns / 1ps

package ilc_pkg;

  localparam int DEPTH      = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int REQ_W      = 3;
  localparam int STAT_W     = 2;

  localparam int IN_BITS    = REQ_W + IDX_W + ITEM_WIDTH;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = ITEM_WIDTH + STAT_W + CNT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_SET    = 3'd2,
    REQ_GET    = 3'd3,
    REQ_BACK   = 3'd4,
    REQ_DELETE = 3'd5,
    REQ_CLEAR  = 3'd6
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    req_e                  req_type;
    logic [IDX_W-1:0]      index;
    logic [ITEM_WIDTH-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [ITEM_WIDTH-1:0] read_data;
    status_e               status;
    logic [CNT_W-1:0]      count;
    logic                  is_empty;
  } res_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [ITEM_WIDTH-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } ram_req_t;

endpackage

FILE: rtl/core/ilc_ram.sv
// Generic simple dual-port RAM with registered read.
// One write port and one read port; no dependencies.
`timescale 1ns / 1ps

module ilc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/core/ilc_ctrl.sv
// Request sequencer for the indexed list: entry count, delete compaction, result register.
// Depends on ilc_pkg; drives the entry RAM through a ram_req_t struct.
`timescale 1ns / 1ps

module ilc_ctrl import ilc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  req_t                  req_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output res_t                  res_o,
  output ram_req_t              ram_o,
  input  logic [ITEM_WIDTH-1:0] rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DEL_RD,
    S_DEL_WR
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  res_t             res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic                  out_free;
  logic                  accept;
  logic                  in_range;
  logic                  nonempty;
  logic                  emit;
  status_e               stat;
  logic [ITEM_WIDTH-1:0] rd_word;

  assign out_free    = !res_valid_q || res_ready_i;
  assign req_ready_o = (state_q == S_IDLE) && out_free;
  assign accept      = req_valid_i && req_ready_o;
  assign in_range    = CNT_W'(req_i.index) < count_q;
  assign nonempty    = count_q != '0;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    ram_o       = '0;
    emit        = 1'b0;
    stat        = ST_OK;
    rd_word     = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            REQ_PUSH: begin
              emit = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                stat = ST_FULL;
              end else begin
                ram_o.we    = 1'b1;
                ram_o.waddr = IDX_W'(count_q);
                ram_o.wdata = req_i.item_value;
                count_d     = count_q + CNT_W'(1);
              end
            end
            REQ_POP: begin
              emit = 1'b1;
              if (nonempty) begin
                count_d = count_q - CNT_W'(1);
              end else begin
                stat = ST_RANGE;
              end
            end
            REQ_SET: begin
              emit = 1'b1;
              if (in_range) begin
                ram_o.we    = 1'b1;
                ram_o.waddr = req_i.index;
                ram_o.wdata = req_i.item_value;
              end else begin
                stat = ST_RANGE;
              end
            end
            REQ_GET: begin
              if (in_range) begin
                ram_o.re    = 1'b1;
                ram_o.raddr = req_i.index;
                state_d     = S_READ;
              end else begin
                emit = 1'b1;
                stat = ST_RANGE;
              end
            end
            REQ_BACK: begin
              if (nonempty) begin
                ram_o.re    = 1'b1;
                ram_o.raddr = IDX_W'(count_q - CNT_W'(1));
                state_d     = S_READ;
              end else begin
                emit = 1'b1;
                stat = ST_RANGE;
              end
            end
            REQ_DELETE: begin
              if (in_range) begin
                ptr_d   = req_i.index;
                state_d = S_DEL_RD;
              end else begin
                emit = 1'b1;
                stat = ST_RANGE;
              end
            end
            REQ_CLEAR: begin
              emit    = 1'b1;
              count_d = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          emit    = 1'b1;
          rd_word = rdata_i;
          state_d = S_IDLE;
        end
      end
      S_DEL_RD: begin
        if (CNT_W'(ptr_q) + CNT_W'(1) < count_q) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = ptr_q + IDX_W'(1);
          state_d     = S_DEL_WR;
        end else if (out_free) begin
          emit    = 1'b1;
          count_d = count_q - CNT_W'(1);
          state_d = S_IDLE;
        end
      end
      S_DEL_WR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = ptr_q;
        ram_o.wdata = rdata_i;
        ptr_d       = ptr_q + IDX_W'(1);
        state_d     = S_DEL_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      res_valid_d     = 1'b1;
      res_d.read_data = rd_word;
      res_d.status    = stat;
      res_d.count     = count_d;
      res_d.is_empty  = (count_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      count_q     <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      count_q     <= count_d;
      res_q       <= res_d;
      res_valid_q <= res_valid_d;
    end
  end

endmodule

FILE: rtl/core/indexed_list_with_compaction.sv
// Push, pop, set, clear and failed requests go straight to the result register; get and
// back go through the RAM read; delete: one RAM read and one write per moved entry.
// Throughput: one word per cycle for single-access requests while the result is taken;
// get and back take no new request until the registered RAM read has returned.
// Reset clears the entry count and the result register; the entry RAM is not cleared.
`timescale 1ns / 1ps

module indexed_list_with_compaction import ilc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // req_type[2:0], index[8:3], item_value[40:9], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // read_data[31:0], status[33:32], count[40:34], is_empty[41], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  req_t                  req;
  res_t                  res;
  ram_req_t              ram_req;
  logic [ITEM_WIDTH-1:0] ram_rdata;

  assign req.req_type   = req_e'(s_axis_tdata[REQ_W-1:0]);
  assign req.index      = s_axis_tdata[REQ_W +: IDX_W];
  assign req.item_value = s_axis_tdata[REQ_W + IDX_W +: ITEM_WIDTH];

  assign m_axis_tdata = OUT_TDATA_W'({res.is_empty, res.count, res.status, res.read_data});

  ilc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res),
    .ram_o       (ram_req),
    .rdata_i     (ram_rdata)
  );

  ilc_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule
